// ===== rtl/cuhm_pkg.sv =====
// cuhm_pkg: shared constants, types and helpers of the processor utilization history monitor
// no dependencies; imported by the interfaces, the divider and the top level
`default_nettype none

package cuhm_pkg;

    // defaults for the top-level parameters
    localparam int unsigned MAX_CPUS_DEF      = 16;
    localparam int unsigned HISTORY_SLOTS_DEF = 900;

    // field widths fixed by the item format
    localparam int unsigned CNT_W    = 64;
    localparam int unsigned EVT_W    = 32;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned RES_W    = 32;
    localparam int unsigned SHARE_W  = 14;
    localparam int unsigned NUM_MET  = 5;
    localparam int unsigned HIST_W   = NUM_MET * SHARE_W;
    localparam int unsigned PREV_W   = 4 * CNT_W + EVT_W;
    localparam int unsigned NUM_W    = CNT_W + SHARE_W;
    localparam int unsigned QUO_W    = 24;
    localparam int unsigned DSH_W    = CNT_W + QUO_W - 1;
    localparam int unsigned STEP_W   = 5;
    localparam int unsigned WIN_W    = 10;
    localparam int unsigned ADDR_W   = 3;

    localparam logic [SHARE_W-1:0] FULL_SHARE = 14'd10000;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNSUP = 1'b1;

    // metric selector codes, also the field order in a history word
    localparam logic [2:0] MET_BUSY   = 3'd0;
    localparam logic [2:0] MET_IDLE   = 3'd1;
    localparam logic [2:0] MET_IRQ    = 3'd2;
    localparam logic [2:0] MET_SYSTEM = 3'd3;
    localparam logic [2:0] MET_USER   = 3'd4;
    localparam logic [2:0] MET_EVENTS = 3'd5;

    // window selector codes
    localparam logic [1:0] WIN_ONE   = 2'd0;
    localparam logic [1:0] WIN_SIXTY = 2'd1;
    localparam logic [1:0] WIN_300   = 2'd2;
    localparam logic [1:0] WIN_900   = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_CPU_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREV,
        ST_ACCUM,
        ST_ROW_SETUP,
        ST_SHARE,
        ST_SHARE_WAIT,
        ST_ROW_WRITE,
        ST_Q_WALK,
        ST_Q_DWAIT,
        ST_Q_EVT,
        ST_Q_OUT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV
    } t_div_state;

    typedef struct packed {
        logic start;
        logic scale;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [WIN_W-1:0] window_len(input logic [1:0] sel);
        logic [WIN_W-1:0] len;
        unique case (sel)
            WIN_ONE:   len = 10'd1;
            WIN_SIXTY: len = 10'd60;
            WIN_300:   len = 10'd300;
            WIN_900:   len = 10'd900;
            default:   len = 10'd1;
        endcase
        return len;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cuhm_if.sv =====
// cuhm_req_if and cuhm_rsp_if: valid/ready channels of the utilization monitor
// depends on cuhm_pkg for field widths
`default_nettype none

interface cuhm_req_if;
    import cuhm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [IDX_W-1:0]     cpu_index;
    logic                 is_total;
    logic [CNT_W-1:0]     idle_time;
    logic [CNT_W-1:0]     kernel_time;
    logic [CNT_W-1:0]     user_time;
    logic [CNT_W-1:0]     irq_time;
    logic [EVT_W-1:0]     irq_events;
    logic                 sample_ok;
    logic [1:0]           window_sel;
    logic [2:0]           metric_sel;

    modport source (
        output valid, req_type, cpu_index, is_total, idle_time, kernel_time,
               user_time, irq_time, irq_events, sample_ok, window_sel, metric_sel,
        input  ready
    );
    modport sink (
        input  valid, req_type, cpu_index, is_total, idle_time, kernel_time,
               user_time, irq_time, irq_events, sample_ok, window_sel, metric_sel,
        output ready
    );
endinterface

interface cuhm_rsp_if;
    import cuhm_pkg::*;
    logic             valid;
    logic             ready;
    logic             status;
    logic [RES_W-1:0] result_value;

    modport source (output valid, status, result_value, input ready);
    modport sink   (input valid, status, result_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/cuhm_div.sv =====
// cuhm_div: iterative unsigned divider, optionally scaling the numerator by 10000 first
// depends on cuhm_pkg; one shift-add or restoring step per cycle
`default_nettype none

module cuhm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cuhm_pkg::t_div_req          i_req,
    input  wire logic [cuhm_pkg::CNT_W-1:0]  i_num,
    input  wire logic [cuhm_pkg::CNT_W-1:0]  i_den,
    output      cuhm_pkg::t_div_stat         o_stat,
    output      logic [cuhm_pkg::QUO_W-1:0]  o_quot
);
    import cuhm_pkg::*;

    t_div_state         r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [NUM_W-1:0]   r_acc, n_acc;
    logic [NUM_W-1:0]   r_mcand, n_mcand;
    logic [DSH_W-1:0]   r_dsh, n_dsh;
    logic [QUO_W-1:0]   r_quot, n_quot;
    logic               r_done, n_done;
    logic [DSH_W:0]     w_diff;
    logic               w_ge;

    // trial subtract of the shifted divisor
    assign w_diff = {1'b0, {(DSH_W-NUM_W){1'b0}}, r_acc} - {1'b0, r_dsh};
    assign w_ge   = !w_diff[DSH_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_step  <= n_step;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_dsh   <= n_dsh;
        r_quot  <= n_quot;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_dsh   = r_dsh;
        n_quot  = r_quot;
        n_done  = 1'b0;
        unique case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_dsh  = {i_den, {(QUO_W-1){1'b0}}};
                    n_quot = '0;
                    if (i_req.scale) begin
                        n_acc   = '0;
                        n_mcand = {{SHARE_W{1'b0}}, i_num};
                        n_step  = '0;
                        n_state = DV_MUL;
                    end else begin
                        n_acc   = {{SHARE_W{1'b0}}, i_num};
                        n_step  = STEP_W'(QUO_W - 1);
                        n_state = DV_DIV;
                    end
                end
            end
            DV_MUL: begin
                // shift-add over the bits of the scale constant
                if (FULL_SHARE[r_step[3:0]]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand = r_mcand << 1;
                if (r_step == STEP_W'(SHARE_W - 1)) begin
                    n_step  = STEP_W'(QUO_W - 1);
                    n_state = DV_DIV;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            DV_DIV: begin
                if (w_ge) begin
                    n_acc = w_diff[NUM_W-1:0];
                end
                n_quot = {r_quot[QUO_W-2:0], w_ge};
                n_dsh  = r_dsh >> 1;
                if (r_step == '0) begin
                    n_done  = 1'b1;
                    n_state = DV_IDLE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            default: n_state = DV_IDLE;
        endcase
    end

    assign o_stat.busy = (r_state != DV_IDLE);
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire

// ===== rtl/cpu_utilization_history_monitor.sv =====
// cpu_utilization_history_monitor: top level, sample/query sequencer and history storage
// depends on cuhm_pkg, cuhm_if (cuhm_req_if, cuhm_rsp_if) and cuhm_div
// a sample writes no row when dropped or during the baseline sweep, one row otherwise, two rows
//   when it closes a sweep; a query walks its window slot by slot, an interrupt count query does
//   not; the shared divider paces the samples and the single history read port paces the
//   queries; one transaction at a time
// reset: synchronous active low; afterwards a clearing pass zeroes the history memory,
//   one entry per cycle over all (MAX_CPUS+1)*HISTORY_SLOTS entries (15300 at defaults)
`default_nettype none

module cpu_utilization_history_monitor #(
    parameter int unsigned MAX_CPUS      = cuhm_pkg::MAX_CPUS_DEF,
    parameter int unsigned HISTORY_SLOTS = cuhm_pkg::HISTORY_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cuhm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready,
    // item channels
    cuhm_req_if.sink                          i_req,
    cuhm_rsp_if.source                        o_rsp
);
    import cuhm_pkg::*;

    localparam int unsigned ROW_LEN    = MAX_CPUS + 1;
    localparam int unsigned HIST_DEPTH = ROW_LEN * HISTORY_SLOTS;
    localparam int unsigned HA_W       = $clog2(HIST_DEPTH);
    localparam int unsigned COL_W      = $clog2(ROW_LEN);
    localparam int unsigned CPU_W      = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int unsigned NW         = $clog2(MAX_CPUS + 1);
    localparam logic [HA_W-1:0] LAST_BASE = HA_W'((HISTORY_SLOTS - 1) * ROW_LEN);
    localparam logic [HA_W-1:0] ROW_STEP  = HA_W'(ROW_LEN);
    localparam logic [HA_W-1:0] LAST_ADDR = HA_W'(HIST_DEPTH - 1);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_cpu_count;
    logic             w_cfg_we;
    logic [NW-1:0]    w_eff;

    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_CPU_COUNT);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CPU_COUNT) ? {{(32-CFG_W){1'b0}}, r_cpu_count} : '0;

    // zero acts as one, anything above the build size acts as the build size
    always_comb begin
        if (r_cpu_count == '0) begin
            w_eff = NW'(1);
        end else if (32'(r_cpu_count) > MAX_CPUS) begin
            w_eff = NW'(MAX_CPUS);
        end else begin
            w_eff = NW'(r_cpu_count);
        end
    end

    // ------------------------------------------------------------------
    // state and latched transaction
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [HA_W-1:0]   r_clr;
    logic              r_baseline;
    logic [HA_W-1:0]   r_wbase;
    logic [MAX_CPUS-1:0] r_prev_vld;
    logic [ROW_LEN-1:0]  r_irq_vld;

    logic [IDX_W-1:0]  r_cpu;
    logic [COL_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_in_idle, r_in_kernel, r_in_user, r_in_irq;
    logic [EVT_W-1:0]  r_in_evt;
    logic              r_in_ok;
    logic [2:0]        r_metric;
    logic [WIN_W-1:0]  r_count;
    logic              r_last;
    logic              r_total_row;

    // deltas of the row being written, and the sweep sums
    logic [CNT_W-1:0]  r_ri, r_rk, r_ru, r_rq, r_tot;
    logic [EVT_W-1:0]  r_ce;
    logic [CNT_W-1:0]  r_sum_idle, r_sum_kernel, r_sum_user, r_sum_irq;
    logic [EVT_W-1:0]  r_sweep_evt;
    logic [2:0]        r_m;
    logic [SHARE_W-1:0] r_share [NUM_MET];

    // query walk
    logic [HA_W-1:0]   r_qbase;
    logic [WIN_W-1:0]  r_issued;
    logic              r_pend;
    logic [QUO_W-1:0]  r_qsum;

    // result staging and output register
    logic              r_res_status;
    logic [RES_W-1:0]  r_res_value;
    logic              r_o_valid;
    logic              r_o_status;
    logic [RES_W-1:0]  r_o_value;

    logic w_in_acc;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // previous-counter store, one entry per processor, valid bits for reset
    // ------------------------------------------------------------------
    logic [PREV_W-1:0] r_prev_mem [MAX_CPUS];
    logic [PREV_W-1:0] r_prev_rd;
    logic              r_prev_vrd;
    logic [CPU_W-1:0]  w_prev_ra, w_cpu;
    logic              w_prev_we;
    logic [PREV_W-1:0] w_prev_wd;

    assign w_prev_ra = CPU_W'(i_req.cpu_index);
    assign w_cpu     = CPU_W'(r_cpu);

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_prev_mem[w_cpu] <= w_prev_wd;
        end
        r_prev_rd  <= r_prev_mem[w_prev_ra];
        r_prev_vrd <= r_prev_vld[w_prev_ra];
    end

    // ------------------------------------------------------------------
    // latest interrupt counts, one per processor plus the total
    // ------------------------------------------------------------------
    logic [EVT_W-1:0]  r_irq_mem [ROW_LEN];
    logic [EVT_W-1:0]  r_irq_rd;
    logic              r_irq_vrd;
    logic [COL_W-1:0]  w_irq_ra, w_irq_wa;
    logic              w_irq_we;
    logic [EVT_W-1:0]  w_irq_wd;

    assign w_irq_ra = i_req.is_total ? COL_W'(MAX_CPUS) : COL_W'(i_req.cpu_index);

    always_ff @(posedge i_clk) begin
        if (w_irq_we) begin
            r_irq_mem[w_irq_wa] <= w_irq_wd;
        end
        r_irq_rd  <= r_irq_mem[w_irq_ra];
        r_irq_vrd <= r_irq_vld[w_irq_ra];
    end

    // ------------------------------------------------------------------
    // history ring: one word per slot and column, five shares per word
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] r_hist_mem [HIST_DEPTH];
    logic [HIST_W-1:0] r_hist_rd;
    logic              w_hist_we;
    logic [HA_W-1:0]   w_hist_wa, w_hist_ra, w_qnext;
    logic [HIST_W-1:0] w_hist_wd;

    // step one slot back with wraparound over the whole ring
    assign w_qnext   = (r_qbase == '0) ? LAST_BASE : (r_qbase - ROW_STEP);
    assign w_hist_ra = w_qnext + HA_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist_mem[w_hist_wa] <= w_hist_wd;
        end
        r_hist_rd <= r_hist_mem[w_hist_ra];
    end

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    t_div_req          w_div_req;
    t_div_stat         w_div_stat;
    logic [CNT_W-1:0]  w_div_num, w_div_den;
    logic [QUO_W-1:0]  w_div_quot;

    cuhm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    // ------------------------------------------------------------------
    // combinational datapath pieces
    // ------------------------------------------------------------------
    logic [PREV_W-1:0] w_pv;
    logic [CNT_W-1:0]  w_pi, w_pk, w_pu, w_pq;
    logic [EVT_W-1:0]  w_pe;
    logic [CNT_W-1:0]  w_ci, w_ck, w_cu, w_cq;
    logic [EVT_W-1:0]  w_ce;
    logic [CNT_W-1:0]  w_di, w_dk, w_du, w_dq;
    logic [CNT_W-1:0]  w_snum;
    logic              w_sat;
    logic [SHARE_W-1:0] w_hfield;
    logic              w_walk_done;
    logic              w_q_unsup;
    logic [COL_W-1:0]  w_in_col;

    // a processor never sampled reads as zero counters
    assign w_pv = r_prev_vrd ? r_prev_rd : '0;
    assign w_pi = w_pv[CNT_W-1:0];
    assign w_pk = w_pv[2*CNT_W-1:CNT_W];
    assign w_pu = w_pv[3*CNT_W-1:2*CNT_W];
    assign w_pq = w_pv[4*CNT_W-1:3*CNT_W];
    assign w_pe = w_pv[PREV_W-1:4*CNT_W];

    // a failed read counts as unchanged counters
    assign w_ci = r_in_ok ? r_in_idle   : w_pi;
    assign w_ck = r_in_ok ? r_in_kernel : w_pk;
    assign w_cu = r_in_ok ? r_in_user   : w_pu;
    assign w_cq = r_in_ok ? r_in_irq    : w_pq;
    assign w_ce = r_in_ok ? r_in_evt    : w_pe;

    // wrapping deltas, idle clamped to kernel
    assign w_dk = w_ck - w_pk;
    assign w_du = w_cu - w_pu;
    assign w_dq = w_cq - w_pq;
    assign w_di = ((w_ci - w_pi) > w_dk) ? w_dk : (w_ci - w_pi);

    assign w_prev_wd = {w_ce, w_cq, w_cu, w_ck, w_ci};

    // numerator of the share being computed
    always_comb begin
        unique case (r_m)
            MET_BUSY:   w_snum = r_tot - r_ri;
            MET_IDLE:   w_snum = r_ri;
            MET_IRQ:    w_snum = r_rq;
            MET_SYSTEM: w_snum = r_rk - r_ri;
            MET_USER:   w_snum = r_ru;
            default:    w_snum = '0;
        endcase
    end
    assign w_sat = (w_snum >= r_tot);

    // selected metric of a history word
    always_comb begin
        unique case (r_metric)
            MET_BUSY:   w_hfield = r_hist_rd[1*SHARE_W-1:0*SHARE_W];
            MET_IDLE:   w_hfield = r_hist_rd[2*SHARE_W-1:1*SHARE_W];
            MET_IRQ:    w_hfield = r_hist_rd[3*SHARE_W-1:2*SHARE_W];
            MET_SYSTEM: w_hfield = r_hist_rd[4*SHARE_W-1:3*SHARE_W];
            MET_USER:   w_hfield = r_hist_rd[5*SHARE_W-1:4*SHARE_W];
            default:    w_hfield = '0;
        endcase
    end

    assign w_walk_done = (r_issued == r_count) && !r_pend;
    // only a query latches the all-processor column here; a sample latches its own
    assign w_in_col    = (i_req.req_type == REQ_QUERY && i_req.is_total) ?
                         COL_W'(MAX_CPUS) : COL_W'(i_req.cpu_index);
    assign w_q_unsup   = (!i_req.is_total && (32'(i_req.cpu_index) >= 32'(w_eff)))
                         || (i_req.metric_sel > MET_EVENTS);

    // ------------------------------------------------------------------
    // sequencer: next state and strobes
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        w_prev_we = 1'b0;
        w_irq_we  = 1'b0;
        w_irq_wa  = COL_W'(r_cpu);
        w_irq_wd  = r_ce;
        w_hist_we = 1'b0;
        w_hist_wa = r_wbase + HA_W'(r_col);
        w_hist_wd = {r_share[4], r_share[3], r_share[2], r_share[1], r_share[0]};
        w_div_req.start = 1'b0;
        w_div_req.scale = 1'b0;
        w_div_num = w_snum;
        w_div_den = r_tot;
        unique case (r_state)
            ST_CLEAR: begin
                w_hist_we = 1'b1;
                w_hist_wa = r_clr;
                w_hist_wd = '0;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_req.req_type == REQ_SAMPLE) begin
                        // samples for processors beyond the count are dropped
                        if (32'(i_req.cpu_index) < 32'(w_eff)) begin
                            n_state = ST_PREV;
                        end
                    end else if (w_q_unsup) begin
                        n_state = ST_Q_OUT;
                    end else if (i_req.metric_sel == MET_EVENTS) begin
                        n_state = ST_Q_EVT;
                    end else begin
                        n_state = ST_Q_WALK;
                    end
                end
            end
            ST_PREV: begin
                w_prev_we = 1'b1;
                n_state   = r_baseline ? ST_ACCUM : ST_IDLE;
            end
            ST_ACCUM: begin
                w_irq_we = 1'b1;
                n_state  = ST_ROW_SETUP;
            end
            ST_ROW_SETUP: begin
                n_state = ST_SHARE;
            end
            ST_SHARE: begin
                if (r_tot != '0 && !w_sat) begin
                    w_div_req.start = 1'b1;
                    w_div_req.scale = 1'b1;
                    n_state = ST_SHARE_WAIT;
                end else if (r_m == MET_USER) begin
                    n_state = ST_ROW_WRITE;
                end
            end
            ST_SHARE_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = (r_m == MET_USER) ? ST_ROW_WRITE : ST_SHARE;
                end
            end
            ST_ROW_WRITE: begin
                w_hist_we = 1'b1;
                if (r_total_row) begin
                    // sweep closes: publish the total interrupt count
                    w_irq_we = 1'b1;
                    w_irq_wa = COL_W'(MAX_CPUS);
                    w_irq_wd = r_sweep_evt;
                    n_state  = ST_IDLE;
                end else if (r_last) begin
                    n_state = ST_ROW_SETUP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_Q_WALK: begin
                if (w_walk_done) begin
                    w_div_req.start = 1'b1;
                    w_div_num = {{(CNT_W-QUO_W){1'b0}}, r_qsum};
                    w_div_den = {{(CNT_W-WIN_W){1'b0}}, r_count};
                    n_state   = ST_Q_DWAIT;
                end
            end
            ST_Q_DWAIT: begin
                if (w_div_stat.done) begin
                    n_state = ST_Q_OUT;
                end
            end
            ST_Q_EVT: begin
                n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cpu_count <= CFG_W'(1);
            r_baseline  <= 1'b0;
            r_wbase     <= '0;
            r_prev_vld  <= '0;
            r_irq_vld   <= '0;
            r_sum_idle  <= '0;
            r_sum_kernel <= '0;
            r_sum_user  <= '0;
            r_sum_irq   <= '0;
            r_sweep_evt <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_we) begin
                r_cpu_count <= pwdata[CFG_W-1:0];
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_prev_we) begin
                r_prev_vld[w_cpu] <= 1'b1;
            end
            if (w_irq_we) begin
                r_irq_vld[w_irq_wa] <= 1'b1;
            end
            // first sweep only records the baseline
            if (r_state == ST_PREV && !r_baseline && r_last) begin
                r_baseline <= 1'b1;
            end
            if (r_state == ST_ACCUM) begin
                r_sum_idle   <= sat_add(r_sum_idle, r_ri);
                r_sum_kernel <= sat_add(r_sum_kernel, r_rk);
                r_sum_user   <= sat_add(r_sum_user, r_ru);
                r_sum_irq    <= sat_add(r_sum_irq, r_rq);
                r_sweep_evt  <= r_sweep_evt + r_ce;
            end
            if (r_state == ST_ROW_WRITE && r_total_row) begin
                r_wbase      <= (r_wbase == LAST_BASE) ? '0 : (r_wbase + ROW_STEP);
                r_sum_idle   <= '0;
                r_sum_kernel <= '0;
                r_sum_user   <= '0;
                r_sum_irq    <= '0;
                r_sweep_evt  <= '0;
            end
            // output register: load frees the sequencer, the sink drains it
            if (r_state == ST_Q_OUT && (!r_o_valid || o_rsp.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cpu       <= i_req.cpu_index;
            r_col       <= w_in_col;
            r_in_idle   <= i_req.idle_time;
            r_in_kernel <= i_req.kernel_time;
            r_in_user   <= i_req.user_time;
            r_in_irq    <= i_req.irq_time;
            r_in_evt    <= i_req.irq_events;
            r_in_ok     <= i_req.sample_ok;
            r_metric    <= i_req.metric_sel;
            r_count     <= window_len(i_req.window_sel);
            r_last      <= (32'(i_req.cpu_index) == (32'(w_eff) - 32'd1));
            r_total_row <= 1'b0;
            r_qbase     <= r_wbase;
            r_issued    <= '0;
            r_pend      <= 1'b0;
            r_qsum      <= '0;
            r_res_status <= STATUS_UNSUP;
            r_res_value  <= '0;
        end
        unique case (r_state)
            ST_PREV: begin
                r_ri <= w_di;
                r_rk <= w_dk;
                r_ru <= w_du;
                r_rq <= w_dq;
                r_ce <= w_ce;
            end
            ST_ROW_SETUP: begin
                r_tot <= sat_add(r_rk, r_ru);
                r_m   <= MET_BUSY;
            end
            ST_SHARE: begin
                if (r_tot == '0) begin
                    r_share[r_m] <= '0;
                    r_m <= r_m + 1'b1;
                end else if (w_sat) begin
                    // share above the full scale saturates
                    r_share[r_m] <= FULL_SHARE;
                    r_m <= r_m + 1'b1;
                end
            end
            ST_SHARE_WAIT: begin
                if (w_div_stat.done) begin
                    r_share[r_m] <= w_div_quot[SHARE_W-1:0];
                    r_m <= r_m + 1'b1;
                end
            end
            ST_ROW_WRITE: begin
                // the closing sample goes on to the all-processor row
                if (!r_total_row && r_last) begin
                    r_total_row <= 1'b1;
                    r_col <= COL_W'(MAX_CPUS);
                    r_ri  <= r_sum_idle;
                    r_rk  <= r_sum_kernel;
                    r_ru  <= r_sum_user;
                    r_rq  <= r_sum_irq;
                end
            end
            ST_Q_WALK: begin
                if (r_issued != r_count) begin
                    r_qbase  <= w_qnext;
                    r_issued <= r_issued + 1'b1;
                    r_pend   <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) begin
                    r_qsum <= r_qsum + QUO_W'(w_hfield);
                end
            end
            ST_Q_DWAIT: begin
                if (w_div_stat.done) begin
                    r_res_status <= STATUS_OK;
                    r_res_value  <= RES_W'(w_div_quot);
                end
            end
            ST_Q_EVT: begin
                r_res_status <= STATUS_OK;
                r_res_value  <= r_irq_vrd ? r_irq_rd : '0;
            end
            default: ;
        endcase
        if (r_state == ST_Q_OUT && (!r_o_valid || o_rsp.ready)) begin
            r_o_status <= r_res_status;
            r_o_value  <= r_res_value;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.result_value = r_o_value;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking testbench of the processor utilization history monitor
// depends on cuhm_pkg, cuhm_if and the cpu_utilization_history_monitor rtl
// drives sample and query transactions, predicts query results in the bench
`default_nettype none

class util_scoreboard;
    logic        exp_status[$];
    logic [31:0] exp_value[$];
    int          errors;

    function void note_query(logic st, logic [31:0] v);
        exp_status.push_back(st);
        exp_value.push_back(v);
    endfunction

    function void check_result(logic st, logic [31:0] v);
        logic        es;
        logic [31:0] ev;
        if (exp_status.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result status=%0d value=%0d", st, v);
            return;
        end
        es = exp_status.pop_front();
        ev = exp_value.pop_front();
        if (es !== st || ev !== v) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected status=%0d value=%0d, got status=%0d value=%0d",
                         es, ev, st, v);
        end
    endfunction

    function int pending();
        return exp_status.size();
    endfunction
endclass

module tb;
    import cuhm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU  = 16;
    localparam int SLOTS = 900;
    localparam int ROW   = NCPU + 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    cuhm_req_if req_ch();
    cuhm_rsp_if rsp_ch();

    cpu_utilization_history_monitor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // timeout: covers the clearing pass and all transactions, with stalls
    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    util_scoreboard sb = new();

    // predictor state, mirrors the block
    logic [4:0]  cfg_count;
    logic [63:0] last_idle[NCPU], last_kernel[NCPU], last_user[NCPU], last_irq[NCPU];
    logic [31:0] last_events[NCPU];
    bit          have_baseline;
    logic [63:0] acc_idle, acc_kernel, acc_user, acc_irq;
    logic [31:0] acc_events;
    logic [13:0] h_busy[ROW*SLOTS], h_idle[ROW*SLOTS], h_sys[ROW*SLOTS];
    logic [13:0] h_user[ROW*SLOTS], h_irq[ROW*SLOTS];
    int          cur_slot;
    logic [31:0] latest_events[ROW];

    function automatic int active_cpus();
        if (cfg_count == 0) return 1;
        if (cfg_count > NCPU) return NCPU;
        return cfg_count;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [13:0] pct_share(logic [63:0] a, logic [63:0] t);
        logic [127:0] q;
        if (a >= t) return 14'd10000;
        q = ({64'd0, a} * 128'd10000) / {64'd0, t};
        return q[13:0];
    endfunction

    function automatic void store_row(int at, logic [63:0] di, logic [63:0] dk,
                                      logic [63:0] du, logic [63:0] dq);
        logic [63:0] t;
        t = add_sat(dk, du);
        if (t == 0) begin
            h_busy[at] = 0; h_idle[at] = 0; h_sys[at] = 0; h_user[at] = 0; h_irq[at] = 0;
        end else begin
            h_busy[at] = pct_share(t - di, t);
            h_idle[at] = pct_share(di, t);
            h_sys[at]  = pct_share(dk - di, t);
            h_user[at] = pct_share(du, t);
            h_irq[at]  = pct_share(dq, t);
        end
    endfunction

    task automatic clear_model();
        cfg_count = 5'd1;
        have_baseline = 0;
        acc_idle = 0; acc_kernel = 0; acc_user = 0; acc_irq = 0; acc_events = 0;
        cur_slot = 0;
        for (int i = 0; i < NCPU; i++) begin
            last_idle[i] = 0; last_kernel[i] = 0; last_user[i] = 0;
            last_irq[i] = 0; last_events[i] = 0;
        end
        for (int i = 0; i < ROW; i++) latest_events[i] = 0;
        for (int i = 0; i < ROW*SLOTS; i++) begin
            h_busy[i] = 0; h_idle[i] = 0; h_sys[i] = 0; h_user[i] = 0; h_irq[i] = 0;
        end
    endtask

    // one request item as driven
    typedef struct {
        logic        rtype;
        logic [3:0]  cpu;
        logic        total;
        logic [63:0] idle, kernel, user, irq;
        logic [31:0] events;
        logic        ok;
        logic [1:0]  win;
        logic [2:0]  met;
    } t_req_item;

    // update the predictor for an accepted transaction; queries push an expectation
    task automatic predict(t_req_item r);
        int n, c, col, cnt, s;
        logic [63:0] ci, ck, cu, cq, di, dk, du, dq;
        logic [31:0] ce, sum;
        n = active_cpus();
        if (r.rtype == REQ_SAMPLE) begin
            c = r.cpu;
            if (c >= n) return;
            if (r.ok) begin
                ci = r.idle; ck = r.kernel; cu = r.user; cq = r.irq; ce = r.events;
            end else begin
                ci = last_idle[c]; ck = last_kernel[c]; cu = last_user[c];
                cq = last_irq[c]; ce = last_events[c];
            end
            if (have_baseline) begin
                di = ci - last_idle[c]; dk = ck - last_kernel[c];
                du = cu - last_user[c]; dq = cq - last_irq[c];
                if (di > dk) di = dk;
                latest_events[c] = ce;
                acc_events += ce;
                acc_idle = add_sat(acc_idle, di);
                acc_kernel = add_sat(acc_kernel, dk);
                acc_user = add_sat(acc_user, du);
                acc_irq = add_sat(acc_irq, dq);
                store_row(cur_slot*ROW + c, di, dk, du, dq);
            end
            last_idle[c] = ci; last_kernel[c] = ck; last_user[c] = cu;
            last_irq[c] = cq; last_events[c] = ce;
            if (c == n - 1) begin
                // sweep closes: all-processor row, advance slot
                if (have_baseline) begin
                    store_row(cur_slot*ROW + NCPU, acc_idle, acc_kernel, acc_user, acc_irq);
                    latest_events[NCPU] = acc_events;
                    cur_slot = (cur_slot + 1 >= SLOTS) ? 0 : cur_slot + 1;
                end
                have_baseline = 1;
                acc_idle = 0; acc_kernel = 0; acc_user = 0; acc_irq = 0; acc_events = 0;
            end
            return;
        end
        if (r.total) col = NCPU;
        else begin
            col = r.cpu;
            if (col >= n) begin
                sb.note_query(STATUS_UNSUP, 0);
                return;
            end
        end
        if (r.met == MET_EVENTS) begin
            sb.note_query(STATUS_OK, latest_events[col]);
            return;
        end
        if (r.met > MET_USER) begin
            sb.note_query(STATUS_UNSUP, 0);
            return;
        end
        case (r.win)
            WIN_ONE:   cnt = 1;
            WIN_SIXTY: cnt = 60;
            WIN_300:   cnt = 300;
            default:   cnt = 900;
        endcase
        s = cur_slot;
        sum = 0;
        for (int i = 0; i < cnt; i++) begin
            s = (s == 0) ? SLOTS - 1 : s - 1;
            case (r.met)
                MET_BUSY:   sum += h_busy[s*ROW + col];
                MET_IDLE:   sum += h_idle[s*ROW + col];
                MET_IRQ:    sum += h_irq[s*ROW + col];
                MET_SYSTEM: sum += h_sys[s*ROW + col];
                default:    sum += h_user[s*ROW + col];
            endcase
        end
        sb.note_query(STATUS_OK, sum / cnt);
    endtask

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side: random backpressure, check every transaction
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result(rsp_ch.status, rsp_ch.result_value);
            rsp_ch.ready <= ($urandom_range(99) < 70);
        end
    end

    // send one request transaction, with a random gap before it;
    // valid stays high after acceptance unless a gap or a drain follows
    task automatic send_req(t_req_item r);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.rtype;
        req_ch.cpu_index  <= r.cpu;
        req_ch.is_total   <= r.total;
        req_ch.idle_time  <= r.idle;
        req_ch.kernel_time <= r.kernel;
        req_ch.user_time  <= r.user;
        req_ch.irq_time   <= r.irq;
        req_ch.irq_events <= r.events;
        req_ch.sample_ok  <= r.ok;
        req_ch.window_sel <= r.win;
        req_ch.metric_sel <= r.met;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predict(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    // apb write, setup then access phase
    task automatic write_cpu_count(logic [4:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= '0; pwdata <= {27'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg_count = v;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req_item query(logic [3:0] c, logic t, logic [1:0] w, logic [2:0] m);
        t_req_item r;
        r = '{default: '0};
        r.rtype = REQ_QUERY; r.cpu = c; r.total = t; r.win = w; r.met = m;
        r.idle = rnd64(); r.kernel = rnd64(); r.user = rnd64(); r.irq = rnd64();
        r.events = $urandom; r.ok = 1'($urandom_range(1));
        return r;
    endfunction

    // sample with counters advanced from the last stored ones by random deltas, or random when wild
    function automatic t_req_item sample(logic [3:0] c, bit wild);
        t_req_item r;
        logic [63:0] dk, di;
        r = '{default: '0};
        r.rtype = REQ_SAMPLE; r.cpu = c; r.total = 1'($urandom_range(1));
        r.win = 2'($urandom_range(3)); r.met = 3'($urandom_range(7));
        r.ok = ($urandom_range(19) != 0);
        r.events = $urandom;
        if (wild) begin
            r.idle = rnd64(); r.kernel = rnd64(); r.user = rnd64(); r.irq = rnd64();
        end else begin
            dk = 64'($urandom_range(100000));
            di = 64'($urandom_range(110000));
            r.kernel = last_kernel[c] + dk;
            r.idle   = last_idle[c] + di;
            r.user   = last_user[c] + 64'($urandom_range(100000));
            r.irq    = last_irq[c] + 64'($urandom_range(30000));
        end
        return r;
    endfunction

    task automatic sweep(int n, bit wild);
        for (int c = 0; c < n; c++) send_req(sample(4'(c), wild));
    endtask

    initial begin
        t_req_item r;
        int n, sent, k;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0; req_ch.cpu_index = '0; req_ch.is_total = 1'b0;
        req_ch.idle_time = '0; req_ch.kernel_time = '0; req_ch.user_time = '0;
        req_ch.irq_time = '0; req_ch.irq_events = '0; req_ch.sample_ok = 1'b0;
        req_ch.window_sel = '0; req_ch.metric_sel = '0;
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: queries before history, then extremes and special cases
        write_cpu_count(5'd2);
        send_req(query(0, 0, WIN_900, MET_BUSY));
        send_req(query(0, 1, WIN_ONE, MET_EVENTS));
        send_req(query(3, 0, WIN_ONE, MET_IDLE));      // processor beyond count
        send_req(query(0, 0, WIN_ONE, 3'd6));          // bad metric
        send_req(query(1, 0, WIN_SIXTY, 3'd7));
        sweep(2, 0);                                    // baseline
        r = sample(5, 0); send_req(r);                  // ignored sample
        sweep(2, 0);
        r = sample(0, 0); r.ok = 1; r.idle = '1; r.kernel = '1; r.user = '1;
        r.irq = '1; r.events = '1; send_req(r);         // saturating sums
        r = sample(1, 0); r.ok = 0; send_req(r);        // failed read
        r = sample(0, 0); r.ok = 1; r.irq = r.irq + 64'd1000000; send_req(r);
        r = sample(1, 1); send_req(r);
        for (int m = 0; m < 8; m++) send_req(query(m[3:0], m[0], m[1:0], m[2:0]));
        send_req(query(0, 1, WIN_300, MET_SYSTEM));
        send_req(query(1, 0, WIN_900, MET_USER));
        send_req(query(15, 1, WIN_ONE, MET_IRQ));

        // random phases over several cpu counts, extremes included
        sent = 0;
        k = 0;
        while (sent < 500) begin
            wait_drained();
            case (k % 5)
                0: write_cpu_count(5'd16);
                1: write_cpu_count(5'd0);
                2: write_cpu_count(5'd31);
                3: write_cpu_count(5'd1);
                default: write_cpu_count(5'($urandom_range(15, 2)));
            endcase
            k++;
            n = active_cpus();
            for (int j = 0; j < 100; j++) begin
                if ($urandom_range(99) < 55) begin
                    sweep(n, $urandom_range(9) == 0);
                    sent += n;
                end else if ($urandom_range(9) == 0) begin
                    send_req(sample(4'($urandom_range(15)), 1'($urandom_range(1))));
                    sent++;
                end else begin
                    // long windows are slow, favor short ones
                    r = query(4'($urandom_range(15)), $urandom_range(3) == 0,
                              ($urandom_range(9) < 7) ? 2'($urandom_range(1))
                                                      : 2'($urandom_range(3)),
                              3'($urandom_range(7)));
                    send_req(r);
                    sent++;
                end
                if (j == 50) wait_drained();   // sender holds off until all results are in
                if (sent >= 500) break;
            end
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
